>>> hw/rtl/dsv_pkg.sv
// ----------------------------------------------------------------------------
// dsv_pkg
// Shared types, constants and calendar helpers for the date string validator.
// ----------------------------------------------------------------------------
package dsv_pkg;

  localparam logic [7:0] SlashCh = 8'h2F;
  localparam logic [7:0] ZeroCh  = 8'h30;
  localparam logic [7:0] NineCh  = 8'h39;

  // Character positions within dd/mm/yyyy.
  localparam logic [3:0] PosSlashA = 4'd2;
  localparam logic [3:0] PosSlashB = 4'd5;
  localparam logic [3:0] PosYearHi = 4'd6;
  localparam logic [3:0] PosYearLo = 4'd8;
  localparam logic [3:0] PosLastCh = 4'd9;
  localparam logic [3:0] DateLen   = 4'd10;
  localparam logic [3:0] PosSat    = 4'd11;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthDec = 4'd12;

  // One finished text as the front hands it to the back. The year is kept as
  // its upper and lower two-digit halves so the leap test needs no divider.
  typedef struct packed {
    logic       fmt_ok;
    logic [6:0] day;
    logic [6:0] month;
    logic [6:0] year_hi;
    logic [6:0] year_lo;
  } dsv_rec_t;

  function automatic logic [6:0] acc10(logic [6:0] acc, logic [3:0] dig);
    logic [10:0] t;
    t = {4'b0, acc} * 11'd10 + {7'b0, dig};
    return t[6:0];
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
      MonthFeb:                                    n = leap ? 5'd29 : 5'd28;
      default:                                     n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

>>> hw/rtl/dsv_front.sv
// ----------------------------------------------------------------------------
// dsv_front
// Takes characters, checks them against their position and accumulates the
// day, month and year digits; emits one record per text on the last char.
// ----------------------------------------------------------------------------
module dsv_front
  import dsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       push,
  output dsv_rec_t   rec
);

  logic [3:0] position;
  logic       format_good;
  logic [6:0] day_accum;
  logic [6:0] month_accum;
  logic [6:0] year_hi;
  logic [6:0] year_lo;

  logic [3:0] position_next;
  logic       format_good_next;
  logic [6:0] day_accum_next;
  logic [6:0] month_accum_next;
  logic [6:0] year_hi_next;
  logic [6:0] year_lo_next;
  logic       is_digit;
  logic       char_ok;
  logic       accept;

  assign accept   = in_valid && in_ready;
  assign is_digit = (ch >= ZeroCh) && (ch <= NineCh);

  always_comb begin
    day_accum_next   = day_accum;
    month_accum_next = month_accum;
    year_hi_next     = year_hi;
    year_lo_next     = year_lo;
    if (position >= DateLen) begin
      char_ok = 1'b0;
    end else if (position == PosSlashA || position == PosSlashB) begin
      char_ok = (ch == SlashCh);
    end else begin
      char_ok = is_digit;
      if (is_digit) begin
        if (position < PosSlashA) begin
          day_accum_next = acc10(day_accum, ch[3:0]);
        end else if (position < PosSlashB) begin
          month_accum_next = acc10(month_accum, ch[3:0]);
        end else if (position < PosYearLo) begin
          year_hi_next = acc10(year_hi, ch[3:0]);
        end else begin
          year_lo_next = acc10(year_lo, ch[3:0]);
        end
      end
    end
    format_good_next = format_good && char_ok;
    position_next    = (position >= DateLen) ? PosSat : position + 4'd1;
  end

  assign push        = accept && last;
  assign rec.fmt_ok  = format_good_next && (position == PosLastCh);
  assign rec.day     = day_accum_next;
  assign rec.month   = month_accum_next;
  assign rec.year_hi = year_hi_next;
  assign rec.year_lo = year_lo_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      position    <= 4'd0;
      format_good <= 1'b1;
      day_accum   <= 7'd0;
      month_accum <= 7'd0;
      year_hi     <= 7'd0;
      year_lo     <= 7'd0;
    end else if (accept) begin
      position    <= position_next;
      format_good <= format_good_next;
      day_accum   <= day_accum_next;
      month_accum <= month_accum_next;
      year_hi     <= year_hi_next;
      year_lo     <= year_lo_next;
    end
  end

  // A finished text always leaves the front ready for a fresh one.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    push |=> (position == 4'd0) && format_good)
    else $error("front did not restart after last character");

  // A record can only pass the format test if all ten characters were seen.
  a_fmt_len: assert property (@(posedge clk) disable iff (rst)
    (push && rec.fmt_ok) |-> (position == PosLastCh) && format_good)
    else $error("format pass without full length");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    position <= PosSat)
    else $error("position beyond saturation");

endmodule

>>> hw/rtl/dsv_queue.sv
// ----------------------------------------------------------------------------
// dsv_queue
// Two-entry record queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dsv_queue
  import dsv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  dsv_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output dsv_rec_t head_rec
);

  dsv_rec_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_rec   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> !pop)
    else $error("pop from empty queue");

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count out of range");

endmodule

>>> hw/rtl/dsv_back.sv
// ----------------------------------------------------------------------------
// dsv_back
// Checks the calendar date of each record and holds the result for output.
// ----------------------------------------------------------------------------
module dsv_back
  import dsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  dsv_rec_t    head_rec,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        valid_res,
  output logic [4:0]  day,
  output logic [3:0]  month,
  output logic [13:0] year
);

  logic        leap;
  logic        month_ok;
  logic        ok;
  logic [13:0] year_full;

  // The year has exactly four digits here, so divisibility by 100 is a zero
  // lower half and divisibility by 400 then rests on the upper half alone.
  assign leap = (head_rec.year_lo != 7'd0) ? (head_rec.year_lo[1:0] == 2'b00)
                                           : (head_rec.year_hi[1:0] == 2'b00);
  assign month_ok  = (head_rec.month >= {3'b0, MonthJan}) &&
                     (head_rec.month <= {3'b0, MonthDec});
  assign ok        = head_rec.fmt_ok && month_ok &&
                     ((head_rec.year_hi != 7'd0) || (head_rec.year_lo != 7'd0)) &&
                     (head_rec.day != 7'd0) &&
                     (head_rec.day <= {2'b0, month_len(head_rec.month[3:0], leap)});
  assign year_full = {7'b0, head_rec.year_hi} * 14'd100 + {7'b0, head_rec.year_lo};

  assign pop = head_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      valid_res <= ok;
      day       <= ok ? head_rec.day[4:0]   : 5'd0;
      month     <= ok ? head_rec.month[3:0] : 4'd0;
      year      <= ok ? year_full           : 14'd0;
    end
  end

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |-> (day == 5'd0) && (month == 4'd0) && (year == 14'd0))
    else $error("invalid result carries nonzero fields");

  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && valid_res) |-> (month >= MonthJan) && (month <= MonthDec) &&
                                 (day != 5'd0) && (year != 14'd0))
    else $error("valid result out of calendar range");

endmodule

>>> hw/rtl/date_string_validator.sv
// ----------------------------------------------------------------------------
// date_string_validator
// Streaming checker for dd/mm/yyyy dates given one character per word.
// ----------------------------------------------------------------------------
// The word with tlast is written into the queue register; its record then
//   passes the calendar check into the output register as the result word.
// Throughput: one character word and one result word per cycle unless stalled.
// The front takes a word in every cycle unless the two-entry queue is full.
// Reset (rst, synchronous, active high) clears the position count, the
//   accumulators, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module date_string_validator
  import dsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Character stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,   // last character of the text
  // Result stream, one word per text.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [0] valid_res, [5:1] day, [9:6] month,
                                 // [23:10] year
);

  logic        push;
  dsv_rec_t    push_rec;
  logic        q_full;
  logic        pop;
  logic        head_valid;
  dsv_rec_t    head_rec;
  logic        valid_res;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;

  // The front only waits for queue space, never for the result side, so a
  // stalled consumer does not hold up characters until the queue fills.
  assign s_tready = !q_full;

  dsv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .ch       (s_tdata),
    .last     (s_tlast),
    .push     (push),
    .rec      (push_rec)
  );

  dsv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  // The back drains one record per cycle into its output register whenever
  // that register is empty or being taken.
  dsv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .valid_res  (valid_res),
    .day        (day),
    .month      (month),
    .year       (year)
  );

  assign m_tdata = {year, month, day, valid_res};

  // A result word can only exist if some text ended before it.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_tvalid)) |-> $past(head_valid))
    else $error("result word without a finished text");

  // While the queue is full the front must not take a character.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !(s_tvalid && s_tready))
    else $error("character taken while queue full");

  a_pop_gate: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid && (!m_tvalid || m_tready))
    else $error("record popped without room for it");

endmodule
